// ----- rtl/core/lsd_radix_sort_32bit_keys_top_defines.svh -----
// Assertion macros for the radix sorter checker.
`ifndef LSD_RADIX_SORT_32BIT_KEYS_TOP_DEFINES_SVH
`define LSD_RADIX_SORT_32BIT_KEYS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LSDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LSDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lsdr_pkg.sv -----
// Shared types and constants of the LSD radix sorter.
`default_nettype none

package lsdr_pkg;

  // Key width fixed by the key ports.
  localparam int unsigned KEY_BITS = 32;

  typedef enum logic [2:0] {
    SORT_IDLE,
    SORT_CLEAR,
    SORT_COUNT,
    SORT_SCAN,
    SORT_SCATTER
  } sort_state_e;

  // Status from the sort engine to the host side.
  typedef struct packed {
    logic busy;
    logic sorted_in_b;
  } sort_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/lsdr_sdp_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module lsdr_sdp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/lsdr_sort_engine.sv -----
// Sort sequencer: histogram clear, count, prefix scan and scatter passes.
`default_nettype none

module lsdr_sort_engine #(
  parameter int unsigned MAX_KEYS   = 1024,
  parameter int unsigned DIGIT_BITS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [$clog2(MAX_KEYS+1)-1:0]       count_i,
  output logic                                     kmem_we_o,
  output logic [$clog2(MAX_KEYS):0]                kmem_waddr_o,
  output logic [lsdr_pkg::KEY_BITS-1:0]            kmem_wdata_o,
  output logic                                     kmem_re_o,
  output logic [$clog2(MAX_KEYS):0]                kmem_raddr_o,
  input  wire logic [lsdr_pkg::KEY_BITS-1:0]       kmem_rdata_i,
  output lsdr_pkg::sort_stat_t                     stat_o
);

  localparam int unsigned AW     = $clog2(MAX_KEYS);
  localparam int unsigned CW     = $clog2(MAX_KEYS + 1);
  localparam int unsigned BW     = DIGIT_BITS;
  localparam int unsigned BINS   = 1 << DIGIT_BITS;
  localparam int unsigned PASSES = (lsdr_pkg::KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned PW     = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int unsigned IW     = (CW > BW + 1) ? CW : BW + 1;
  localparam int unsigned SW     = $clog2(lsdr_pkg::KEY_BITS);

  lsdr_pkg::sort_state_e state_q, state_d;

  logic [IW-1:0] idx_q;
  logic [CW-1:0] n_q;
  logic [PW-1:0] pass_q;
  logic          src_q;
  logic          sorted_b_q;
  logic [CW-1:0] total_q;
  logic          v1_q, v2_q, sv_q;
  logic [BW-1:0] d2_q, sa_q;
  logic [lsdr_pkg::KEY_BITS-1:0] key2_q;
  logic          fwd_v_q;
  logic [BW-1:0] fwd_a_q;
  logic [CW-1:0] fwd_d_q;

  logic          issue_key, issue_bin, clear_act, key_phase;
  logic          phase_end, last_pass;
  logic [SW-1:0] shift;
  logic [lsdr_pkg::KEY_BITS-1:0] key_shifted;
  logic [BW-1:0] d1;
  logic [CW-1:0] cur, cur_inc;

  logic          hist_we, hist_re;
  logic [BW-1:0] hist_waddr, hist_raddr;
  logic [CW-1:0] hist_wdata, hist_rdata;

  assign key_phase = (state_q == lsdr_pkg::SORT_COUNT) ||
                     (state_q == lsdr_pkg::SORT_SCATTER);
  assign issue_key = key_phase && (idx_q < IW'(n_q));
  assign issue_bin = (state_q == lsdr_pkg::SORT_SCAN) && (idx_q < IW'(BINS));
  assign clear_act = (state_q == lsdr_pkg::SORT_CLEAR);
  assign last_pass = (pass_q == PW'(PASSES - 1));

  assign shift       = SW'(pass_q) * SW'(DIGIT_BITS);
  assign key_shifted = kmem_rdata_i >> shift;
  assign d1          = key_shifted[BW-1:0];

  // Forward the previous update when the same bin comes back to back.
  assign cur     = (fwd_v_q && (fwd_a_q == d2_q)) ? fwd_d_q : hist_rdata;
  assign cur_inc = cur + CW'(1);

  always_comb begin
    phase_end = 1'b0;
    unique case (state_q)
      lsdr_pkg::SORT_CLEAR:   phase_end = (idx_q == IW'(BINS - 1));
      lsdr_pkg::SORT_COUNT,
      lsdr_pkg::SORT_SCATTER: phase_end = !issue_key && !v1_q && !v2_q;
      lsdr_pkg::SORT_SCAN:    phase_end = !issue_bin && !sv_q;
      default:                phase_end = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsdr_pkg::SORT_IDLE: begin
        if (start_i) state_d = lsdr_pkg::SORT_CLEAR;
      end
      lsdr_pkg::SORT_CLEAR: begin
        if (phase_end) state_d = lsdr_pkg::SORT_COUNT;
      end
      lsdr_pkg::SORT_COUNT: begin
        if (phase_end) state_d = lsdr_pkg::SORT_SCAN;
      end
      lsdr_pkg::SORT_SCAN: begin
        if (phase_end) state_d = lsdr_pkg::SORT_SCATTER;
      end
      lsdr_pkg::SORT_SCATTER: begin
        if (phase_end) state_d = last_pass ? lsdr_pkg::SORT_IDLE : lsdr_pkg::SORT_CLEAR;
      end
      default: state_d = lsdr_pkg::SORT_IDLE;
    endcase
  end

  // Memory port drive.
  always_comb begin
    hist_we      = 1'b0;
    hist_waddr   = d2_q;
    hist_wdata   = cur_inc;
    hist_re      = 1'b0;
    hist_raddr   = d1;
    kmem_re_o    = issue_key;
    kmem_raddr_o = {src_q, idx_q[AW-1:0]};
    kmem_we_o    = 1'b0;
    kmem_waddr_o = {~src_q, cur[AW-1:0]};
    kmem_wdata_o = key2_q;
    unique case (state_q)
      lsdr_pkg::SORT_CLEAR: begin
        hist_we    = clear_act;
        hist_waddr = idx_q[BW-1:0];
        hist_wdata = '0;
      end
      lsdr_pkg::SORT_COUNT: begin
        hist_we = v2_q;
        hist_re = v1_q;
      end
      lsdr_pkg::SORT_SCAN: begin
        hist_we    = sv_q;
        hist_waddr = sa_q;
        hist_wdata = total_q;
        hist_re    = issue_bin;
        hist_raddr = idx_q[BW-1:0];
      end
      lsdr_pkg::SORT_SCATTER: begin
        hist_we   = v2_q;
        hist_re   = v1_q;
        kmem_we_o = v2_q;
      end
      default: begin
        hist_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lsdr_pkg::SORT_IDLE;
      idx_q      <= '0;
      n_q        <= '0;
      pass_q     <= '0;
      src_q      <= 1'b0;
      sorted_b_q <= 1'b0;
      total_q    <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      sv_q       <= 1'b0;
      fwd_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        idx_q <= '0;
      end else if (issue_key || issue_bin || clear_act) begin
        idx_q <= idx_q + IW'(1);
      end
      v1_q    <= issue_key;
      v2_q    <= v1_q;
      sv_q    <= issue_bin;
      fwd_v_q <= v2_q && key_phase;
      if (state_q == lsdr_pkg::SORT_IDLE && start_i) begin
        n_q    <= count_i;
        pass_q <= '0;
        src_q  <= 1'b0;
      end
      if (state_q == lsdr_pkg::SORT_COUNT && phase_end) begin
        total_q <= '0;
      end else if (sv_q && state_q == lsdr_pkg::SORT_SCAN) begin
        total_q <= total_q + hist_rdata;
      end
      if (state_q == lsdr_pkg::SORT_SCATTER && phase_end) begin
        pass_q <= pass_q + PW'(1);
        src_q  <= ~src_q;
        if (last_pass) sorted_b_q <= ~src_q;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    d2_q    <= d1;
    key2_q  <= kmem_rdata_i;
    sa_q    <= idx_q[BW-1:0];
    fwd_a_q <= d2_q;
    fwd_d_q <= cur_inc;
  end

  lsdr_sdp_ram #(
    .WIDTH (CW),
    .DEPTH (BINS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  assign stat_o.busy        = (state_q != lsdr_pkg::SORT_IDLE);
  assign stat_o.sorted_in_b = sorted_b_q;

endmodule

`default_nettype wire

// ----- rtl/core/lsd_radix_sort_32bit_keys_top.sv -----
// Top level of the LSD radix sorter for unsigned 32-bit keys.
//
//   channel   direction  handshake            payload
//   command   in         start, busy          mode_i, key_i, last_i
//   result    out        res_valid_o (strobe) sorted_key_o, final_res_o, overflowed_o
//
// An item is taken on a rising edge with start high and busy low. Loads and reads
// are taken one per cycle while busy is low; a read's result shows for one cycle,
// in the cycle after the read. A load marked last starts the sort: busy stays high
// while the engine runs its passes (four by default), each a clear, count, scan and
// scatter through the single histogram RAM port pair.
// Reset clears all control state; key RAM contents are undefined until loaded.
// The receiver cannot stall: results are strobes.
`default_nettype none

module lsd_radix_sort_32bit_keys_top #(
  parameter int unsigned MAX_KEYS   = 1024,
  parameter int unsigned DIGIT_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          mode_i,
  input  wire logic [lsdr_pkg::KEY_BITS-1:0] key_i,
  input  wire logic                          last_i,
  output logic                               res_valid_o,
  output logic [lsdr_pkg::KEY_BITS-1:0]      sorted_key_o,
  output logic                               final_res_o,
  output logic                               overflowed_o
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  lsdr_pkg::sort_stat_t stat;

  logic [CW-1:0] key_count_q, key_count_d;
  logic [CW-1:0] read_ptr_q, read_ptr_d;
  logic          ovf_q, ovf_d;
  logic          sorted_q, sorted_d;
  logic          res_valid_q;
  logic          fin_q, ovfo_q;

  logic          accept, ld, rd, rd_ok, has_room;
  logic [CW-1:0] kc_base;
  logic          ovf_base;

  // Host and engine ports into the key RAM.
  logic                          h_we, e_we, k_we;
  logic [AW:0]                   h_waddr, e_waddr, k_waddr;
  logic [lsdr_pkg::KEY_BITS-1:0] e_wdata, k_wdata;
  logic                          h_re, e_re, k_re;
  logic [AW:0]                   h_raddr, e_raddr, k_raddr;
  logic [lsdr_pkg::KEY_BITS-1:0] k_rdata;

  assign busy   = stat.busy;
  assign accept = start && !busy;
  assign ld     = accept && !mode_i;
  assign rd     = accept && mode_i;

  // A load after a sorted set opens a new set.
  assign kc_base  = sorted_q ? '0 : key_count_q;
  assign ovf_base = sorted_q ? 1'b0 : ovf_q;
  assign has_room = (kc_base < CW'(MAX_KEYS));

  assign rd_ok = rd && sorted_q && (read_ptr_q < key_count_q);

  always_comb begin
    key_count_d = key_count_q;
    ovf_d       = ovf_q;
    sorted_d    = sorted_q;
    read_ptr_d  = read_ptr_q;
    if (ld) begin
      key_count_d = has_room ? (kc_base + CW'(1)) : kc_base;
      ovf_d       = ovf_base || !has_room;
      sorted_d    = last_i;
      read_ptr_d  = '0;
    end else if (rd_ok) begin
      read_ptr_d  = read_ptr_q + CW'(1);
    end
  end

  // Loads fill store A; reads fetch from whichever store holds the result.
  assign h_we    = ld && has_room;
  assign h_waddr = {1'b0, kc_base[AW-1:0]};
  assign h_re    = rd_ok;
  assign h_raddr = {stat.sorted_in_b, read_ptr_q[AW-1:0]};

  // Hand the key RAM to the engine while it sorts.
  assign k_we    = busy ? e_we    : h_we;
  assign k_waddr = busy ? e_waddr : h_waddr;
  assign k_wdata = busy ? e_wdata : key_i;
  assign k_re    = busy ? e_re    : h_re;
  assign k_raddr = busy ? e_raddr : h_raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      read_ptr_q  <= '0;
      ovf_q       <= 1'b0;
      sorted_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      key_count_q <= key_count_d;
      read_ptr_q  <= read_ptr_d;
      ovf_q       <= ovf_d;
      sorted_q    <= sorted_d;
      res_valid_q <= rd_ok;
    end
  end

  // Hold the result flags beside the RAM read data.
  always_ff @(posedge clk_i) begin
    if (rd_ok) begin
      fin_q  <= ((read_ptr_q + CW'(1)) == key_count_q);
      ovfo_q <= ovf_q;
    end
  end

  lsdr_sdp_ram #(
    .WIDTH (lsdr_pkg::KEY_BITS),
    .DEPTH (2 << AW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .re_i    (k_re),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  lsdr_sort_engine #(
    .MAX_KEYS   (MAX_KEYS),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (ld && last_i),
    .count_i      (key_count_d),
    .kmem_we_o    (e_we),
    .kmem_waddr_o (e_waddr),
    .kmem_wdata_o (e_wdata),
    .kmem_re_o    (e_re),
    .kmem_raddr_o (e_raddr),
    .kmem_rdata_i (k_rdata),
    .stat_o       (stat)
  );

  assign res_valid_o  = res_valid_q;
  assign sorted_key_o = k_rdata;
  assign final_res_o  = fin_q;
  assign overflowed_o = ovfo_q;

endmodule

`default_nettype wire

// ----- rtl/core/lsdr_checker.sv -----
// Port-level checker for the radix sorter, bound to the top level.
`default_nettype none
`include "lsd_radix_sort_32bit_keys_top_defines.svh"

module lsdr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_i,
  input wire logic mode_i,
  input wire logic last_i,
  input wire logic res_valid_i,
  input wire logic final_res_i
);

  // Results come only from reads, never while sorting.
  `LSDR_ASSERT_NOW(a_res_idle, clk_i, rst_ni, res_valid_i, !busy_i, "result while sorting")
  `LSDR_ASSERT_NOW(a_res_after_read, clk_i, rst_ni, res_valid_i,
                   $past(start_i && !busy_i && mode_i), "result without a read")
  // Nothing follows the final key of a set.
  `LSDR_ASSERT_NEXT(a_final_ends, clk_i, rst_ni, res_valid_i && final_res_i,
                    !res_valid_i, "result after final key")
  // Sorting starts only on a load marked last.
  `LSDR_ASSERT_NOW(a_busy_cause, clk_i, rst_ni, $rose(busy_i),
                   $past(start_i && !mode_i && last_i), "sort without last load")

endmodule

bind lsd_radix_sort_32bit_keys_top lsdr_checker u_lsdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .mode_i      (mode_i),
  .last_i      (last_i),
  .res_valid_i (res_valid_o),
  .final_res_i (final_res_o)
);

`default_nettype wire
